### sv/pcs_pkg.sv
// Shared types, constants and codes of the pressure calibration sequencer.
package pcs_pkg;

    localparam int W_PRESS = 17;
    localparam int W_AVG   = 25;
    localparam int W_PROG  = 9;
    localparam int W_NUM   = 25;
    localparam int W_DEN   = 18;

    localparam logic [7:0]         ALPHA_MIN      = 8'd51;
    localparam logic [7:0]         ALPHA_MAX      = 8'd253;
    localparam logic [7:0]         ALPHA_RST      = 8'd128;
    localparam logic [W_PRESS-1:0] SETPOINT_RST   = 17'd50000;
    localparam logic [W_PRESS-1:0] BASE_RST       = 17'd101325;
    localparam logic [W_PRESS-1:0] SAFE_LOW_RST   = 17'd26000;
    localparam logic [W_PRESS-1:0] SAFE_HIGH_RST  = 17'd108000;
    localparam logic [15:0]        GROUND_DLY_RST = 16'd5000;
    localparam logic [11:0]        LEAK_MARG_RST  = 12'd100;
    localparam logic [W_AVG-1:0]   AVG_RST        = 25'(101325 * 256);

    localparam logic [W_PROG-1:0] PROG_FULL = 9'd256;
    localparam logic [W_PROG-1:0] PROG_HALF = 9'd128;

    // quotient bits produced by the serial divider
    localparam int               DIV_STEPS = 9;
    localparam logic [3:0]       DIV_LAST  = 4'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PH_GROUND  = 2'd0,
        PH_PUMPING = 2'd1,
        PH_LEAKING = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CFG_ALPHA     = 3'd0,
        CFG_SETPOINT  = 3'd1,
        CFG_BASE      = 3'd2,
        CFG_SAFE_LOW  = 3'd3,
        CFG_SAFE_HIGH = 3'd4,
        CFG_GROUND    = 3'd5,
        CFG_LEAK      = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RAW,
        ST_MUL_AVG,
        ST_SUM,
        ST_EVAL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [W_NUM-1:0] num;
        logic [W_DEN-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [W_PROG-1:0] quot;
    } t_div_rsp;

endpackage

### sv/pcs_ifs.sv
// Channel interfaces of the pressure calibration sequencer: command, result, config.
interface pcs_in_if import pcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [W_PRESS-1:0] raw_pressure;
    logic               sample_ok;
    logic [31:0]        now_ms;

    modport source (output valid, opcode, raw_pressure, sample_ok, now_ms, input ready);
    modport sink   (input valid, opcode, raw_pressure, sample_ok, now_ms, output ready);
endinterface

interface pcs_out_if import pcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         phase;
    logic               active;
    logic               pump_on;
    logic [W_PRESS-1:0] filtered_pressure;
    logic [W_PROG-1:0]  progress_q8;
    logic               fault;
    logic               done_res;

    modport source (output valid, phase, active, pump_on, filtered_pressure, progress_q8,
                    fault, done_res, input ready);
    modport sink   (input valid, phase, active, pump_on, filtered_pressure, progress_q8,
                    fault, done_res, output ready);
endinterface

interface pcs_cfg_if import pcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         index;
    logic [W_PRESS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/pressure_calibration_sequencer_top.sv
// Top level of the pressure calibration sequencer: command decode, sequencer and datapath.
//
//  channel  | dir | payload                                              | beat when
//  ---------+-----+------------------------------------------------------+-----------------
//  i_in     | in  | opcode, raw_pressure, sample_ok, now_ms              | valid & ready
//  o_out    | out | phase, active, pump_on, filtered_pressure,           | valid & ready
//           |     | progress_q8, fault, done_res                         |
//  i_cfg    | in  | index (register number), data                        | valid & ready
//
//  One command at a time. Stop, idle sample and unused opcode go straight to EMIT; a start
//  with a good read runs MUL_RAW, MUL_AVG and SUM; an active sample adds EVAL (ground
//  phase), and in pumping and leaking FIN, after DIV if it launches the nine-step divider
//  for progress. The 9x25 multiplier is shared by both terms of the average update.
//  Reset (synchronous, active low) loads the register defaults and the ambient average.
//  A held result beat in the output register does not stop the next command from being
//  taken; only a new result waits for the register to drain. i_cfg is always ready.
module pressure_calibration_sequencer_top import pcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pcs_in_if.sink    i_in,
    pcs_out_if.source o_out,
    pcs_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [7:0]         r_alpha;
    logic [W_PRESS-1:0] r_setpoint;
    logic [W_PRESS-1:0] r_base;
    logic [W_PRESS-1:0] r_safe_lo;
    logic [W_PRESS-1:0] r_safe_hi;
    logic [15:0]        r_delay;
    logic [11:0]        r_leak;

    // sequencer and architectural state
    t_state             r_state,    n_state;
    t_phase             r_phase,    n_phase;
    logic               r_active,   n_active;
    logic               r_pump,     n_pump;
    logic [W_AVG-1:0]   r_avg,      n_avg;
    logic [31:0]        r_stamp,    n_stamp;
    logic [W_PROG-1:0]  r_progress, n_progress;
    logic               r_fault,    n_fault;
    logic               r_done,     n_done;

    // captured command
    logic [1:0]         r_op,  n_op;
    logic [W_PRESS-1:0] r_raw, n_raw;
    logic [31:0]        r_now, n_now;

    // datapath working registers
    logic [33:0]        r_p1, n_p1;
    logic [33:0]        r_p2, n_p2;
    logic [W_PROG-1:0]  r_quot, n_quot;

    // output register
    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_o_phase;
    logic               r_o_active;
    logic               r_o_pump;
    logic [W_PRESS-1:0] r_o_filt;
    logic [W_PROG-1:0]  r_o_prog;
    logic               r_o_fault;
    logic               r_o_done;
    logic               out_load;

    // shared multiplier
    logic [8:0]         mul_a;
    logic [W_AVG-1:0]   mul_b;
    logic [33:0]        mul_p;

    // datapath combinational values
    logic [33:0]        avg_sum;
    logic [W_PRESS-1:0] avg_int;
    logic               avg_frac_nz;
    logic               out_of_bounds;
    logic [31:0]        elapsed;
    logic [W_PRESS:0]   diff;
    logic               diff_zero;
    logic [W_PRESS:0]   diff_mag;
    logic [W_NUM:0]     num_pump;
    logic [W_NUM:0]     num_leak;
    logic [W_NUM:0]     num_sel;
    logic [W_NUM:0]     num_eff;
    logic               below_set;
    logic [W_PRESS:0]   leak_thr;
    logic               leak_end;
    logic [W_PROG:0]    leak_prog;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    pcs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);

    // configuration writes; alpha is clamped to its legal window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RST;
            r_setpoint <= SETPOINT_RST;
            r_base     <= BASE_RST;
            r_safe_lo  <= SAFE_LOW_RST;
            r_safe_hi  <= SAFE_HIGH_RST;
            r_delay    <= GROUND_DLY_RST;
            r_leak     <= LEAK_MARG_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_ALPHA: begin
                    if (i_cfg.data[7:0] < ALPHA_MIN) begin
                        r_alpha <= ALPHA_MIN;
                    end else if (i_cfg.data[7:0] > ALPHA_MAX) begin
                        r_alpha <= ALPHA_MAX;
                    end else begin
                        r_alpha <= i_cfg.data[7:0];
                    end
                end
                CFG_SETPOINT:  r_setpoint <= i_cfg.data;
                CFG_BASE:      r_base     <= i_cfg.data;
                CFG_SAFE_LOW:  r_safe_lo  <= i_cfg.data;
                CFG_SAFE_HIGH: r_safe_hi  <= i_cfg.data;
                CFG_GROUND:    r_delay    <= i_cfg.data[15:0];
                CFG_LEAK:      r_leak     <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // one multiplier: (256 - alpha) * raw first, then alpha * average
    always_comb begin
        if (r_state == ST_MUL_RAW) begin
            mul_a = 9'd256 - {1'b0, r_alpha};
            mul_b = {8'd0, r_raw};
        end else begin
            mul_a = {1'b0, r_alpha};
            mul_b = r_avg;
        end
    end
    assign mul_p = 34'(mul_a * mul_b);

    // rounded update: drop eight fraction bits after adding one half
    assign avg_sum = {r_p1[25:0], 8'd0} + r_p2 + 34'd128;

    assign avg_int     = r_avg[W_AVG-1:8];
    assign avg_frac_nz = |r_avg[7:0];

    // bounds are inclusive on the Q.8 value
    assign out_of_bounds = (avg_int < r_safe_lo) || (avg_int > r_safe_hi)
                         || ((avg_int == r_safe_hi) && avg_frac_nz);

    assign elapsed = r_now - r_stamp;

    assign diff      = {1'b0, r_base} - {1'b0, r_setpoint};
    assign diff_zero = (diff == '0);
    assign diff_mag  = diff[W_PRESS] ? (~diff + 18'd1) : diff;

    assign num_pump = {1'b0, r_base, 8'd0} - {1'b0, r_avg};
    assign num_leak = {1'b0, r_avg} - {1'b0, r_setpoint, 8'd0};
    assign num_sel  = (r_phase == PH_PUMPING) ? num_pump : num_leak;
    // base below setpoint: flip the sign so the divisor stays positive
    assign num_eff  = diff[W_PRESS] ? (~num_sel + 26'd1) : num_sel;

    assign below_set = (avg_int < r_setpoint) || ((avg_int == r_setpoint) && !avg_frac_nz);

    // a margin above base gives a negative threshold that is always met
    assign leak_thr  = {1'b0, r_base} - {6'd0, r_leak};
    assign leak_end  = leak_thr[W_PRESS] || (avg_int >= leak_thr[W_PRESS-1:0]);
    assign leak_prog = {1'b0, r_quot} + {1'b0, PROG_HALF};

    assign div_req.start = (r_state == ST_EVAL) && !out_of_bounds
                         && ((r_phase == PH_PUMPING) || (r_phase == PH_LEAKING))
                         && !diff_zero && !num_eff[W_NUM];
    assign div_req.num   = num_eff[W_NUM-1:0];
    assign div_req.den   = {diff_mag[W_PRESS-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_GROUND;
            r_active   <= 1'b0;
            r_pump     <= 1'b0;
            r_avg      <= AVG_RST;
            r_stamp    <= '0;
            r_progress <= '0;
            r_fault    <= 1'b0;
            r_done     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_active   <= n_active;
            r_pump     <= n_pump;
            r_avg      <= n_avg;
            r_stamp    <= n_stamp;
            r_progress <= n_progress;
            r_fault    <= n_fault;
            r_done     <= n_done;
            r_ovalid   <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_raw  <= n_raw;
        r_now  <= n_now;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_quot <= n_quot;
        if (out_load) begin
            r_o_phase  <= r_phase;
            r_o_active <= r_active;
            r_o_pump   <= r_pump;
            r_o_filt   <= r_avg[W_AVG-1:8];
            r_o_prog   <= r_progress;
            r_o_fault  <= r_fault;
            r_o_done   <= r_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_active   = r_active;
        n_pump     = r_pump;
        n_avg      = r_avg;
        n_stamp    = r_stamp;
        n_progress = r_progress;
        n_fault    = r_fault;
        n_done     = r_done;
        n_op       = r_op;
        n_raw      = r_raw;
        n_now      = r_now;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_quot     = r_quot;
        out_load   = 1'b0;
        n_ovalid   = r_ovalid && !o_out.ready;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.opcode;
                    n_raw   = i_in.raw_pressure;
                    n_now   = i_in.now_ms;
                    n_fault = 1'b0;
                    n_done  = 1'b0;
                    n_state = ST_EMIT;
                    case (i_in.opcode)
                        OP_START: begin
                            if (!r_active) begin
                                n_active   = 1'b1;
                                n_stamp    = i_in.now_ms;
                                n_phase    = PH_GROUND;
                                n_progress = '0;
                            end
                            if (i_in.sample_ok) begin
                                n_state = ST_MUL_RAW;
                            end else begin
                                n_active = 1'b0;
                                n_fault  = 1'b1;
                            end
                        end
                        OP_STOP: begin
                            n_active = 1'b0;
                            n_pump   = 1'b0;
                        end
                        OP_SAMPLE: begin
                            if (r_active && i_in.sample_ok) begin
                                n_state = ST_MUL_RAW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL_RAW: begin
                n_p1    = mul_p;
                n_state = ST_MUL_AVG;
            end
            ST_MUL_AVG: begin
                n_p2    = mul_p;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_avg   = avg_sum[32:8];
                // a start takes no bounds check and no phase step
                n_state = (r_op == OP_START) ? ST_EMIT : ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_EMIT;
                if (out_of_bounds) begin
                    n_pump     = 1'b0;
                    n_active   = 1'b0;
                    n_progress = '0;
                    n_fault    = 1'b1;
                end else begin
                    case (r_phase)
                        PH_GROUND: begin
                            if (elapsed >= {16'd0, r_delay}) begin
                                n_pump  = 1'b1;
                                n_phase = PH_PUMPING;
                            end
                        end
                        PH_PUMPING, PH_LEAKING: begin
                            if (div_req.start) begin
                                n_state = ST_DIV;
                            end else begin
                                // negative ratio reads as zero
                                n_quot  = '0;
                                n_state = ST_FIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_quot  = div_rsp.quot;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_EMIT;
                case (r_phase)
                    PH_PUMPING: begin
                        if (!diff_zero) begin
                            n_progress = r_quot;
                        end
                        if (below_set) begin
                            n_pump  = 1'b0;
                            n_phase = PH_LEAKING;
                        end
                    end
                    PH_LEAKING: begin
                        if (!diff_zero) begin
                            n_progress = (leak_prog > {1'b0, PROG_FULL}) ? PROG_FULL
                                                                         : leak_prog[W_PROG-1:0];
                        end
                        if (leak_end) begin
                            n_pump     = 1'b0;
                            n_active   = 1'b0;
                            n_progress = PROG_FULL;
                            n_done     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.phase             = r_o_phase;
    assign o_out.active            = r_o_active;
    assign o_out.pump_on           = r_o_pump;
    assign o_out.filtered_pressure = r_o_filt;
    assign o_out.progress_q8       = r_o_prog;
    assign o_out.fault             = r_o_fault;
    assign o_out.done_res          = r_o_done;

    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fault) |-> !o_out.active)
        else $error("fault beat with sequence still active");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res)
            |-> (o_out.progress_q8 == PROG_FULL && !o_out.pump_on && !o_out.fault))
        else $error("finishing beat with inconsistent fields");

    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.progress_q8 <= PROG_FULL))
        else $error("progress above full scale");

    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == ST_DIV))
        else $error("divider launched without waiting for it");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider result with no one waiting");

endmodule

### sv/pcs_divider.sv
// Restoring serial divider for the progress ratio, one quotient bit per cycle.
module pcs_divider import pcs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [W_NUM-1:0]  r_rem;
    logic [W_NUM:0]    r_dsh;
    logic [W_PROG-1:0] r_q;
    logic              r_sat;
    logic [W_PROG-1:0] r_quot;

    logic              ge;
    logic [W_PROG-1:0] q_step;

    assign ge     = {1'b0, r_rem} >= r_dsh;
    assign q_step = {r_q[W_PROG-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_LAST;
                r_rem  <= i_req.num;
                r_dsh  <= {i_req.den, 8'd0};
                r_q    <= '0;
                // quotient would need more than nine bits: saturate
                r_sat  <= {2'b00, i_req.num} >= {i_req.den, 9'd0};
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh[W_NUM-1:0];
                end
                r_q   <= q_step;
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= (r_sat || q_step > PROG_FULL) ? PROG_FULL : q_step;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
